FILE: rtl/dmlp_pkg.sv
`timescale 1ns / 1ps
package dmlp_pkg;

  localparam int IN_COUNT   = 7;
  localparam int HIDDEN_ONE = 32;
  localparam int HIDDEN_TWO = 32;
  localparam int OUT_COUNT  = 1;
  localparam int FRAC_BITS  = 12;

  localparam int W1_BASE = 0;
  localparam int W2_BASE = W1_BASE + HIDDEN_ONE * IN_COUNT;
  localparam int W3_BASE = W2_BASE + HIDDEN_TWO * HIDDEN_ONE;
  localparam int W_DEPTH = W3_BASE + OUT_COUNT * HIDDEN_TWO;
  localparam int B1_BASE = 0;
  localparam int B2_BASE = B1_BASE + HIDDEN_ONE;
  localparam int B3_BASE = B2_BASE + HIDDEN_TWO;
  localparam int B_DEPTH = B3_BASE + OUT_COUNT;
  localparam int SEG_SHIFT = FRAC_BITS - 2;

  localparam int WAW = $clog2(W_DEPTH);
  localparam int BAW = $clog2(B_DEPTH);
  localparam int HMAX = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
  localparam int VDEPTH = IN_COUNT + HIDDEN_ONE + HIDDEN_TWO;
  localparam int VAW = $clog2(VDEPTH);
  localparam int CW = $clog2(HMAX + 1) + 1;
  localparam int ACC_W = 40;

  typedef enum logic [1:0] {
    CMD_WEIGHT  = 2'd0,
    CMD_BIAS    = 2'd1,
    CMD_FEATURE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    LAYER_ONE = 2'd0,
    LAYER_TWO = 2'd1,
    LAYER_OUT = 2'd2
  } layer_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_BIAS,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [10:0]        index;
    logic signed [15:0] value;
    logic               last_element;
  } req_t;

  typedef struct packed {
    logic [2:0]         out_index;
    logic signed [15:0] out_value;
    logic               out_last;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic mac;
    logic add_bias;
  } mac_ctl_t;

  function automatic logic [15:0] tanh_entry(input logic [4:0] k);
    logic [15:0] r;
    case (k)
      5'd0:  r = 16'd0;
      5'd1:  r = 16'd8025;
      5'd2:  r = 16'd15143;
      5'd3:  r = 16'd20813;
      5'd4:  r = 16'd24956;
      5'd5:  r = 16'd27797;
      5'd6:  r = 16'd29660;
      5'd7:  r = 16'd30847;
      5'd8:  r = 16'd31589;
      5'd9:  r = 16'd32048;
      5'd10: r = 16'd32330;
      5'd11: r = 16'd32501;
      5'd12: r = 16'd32606;
      5'd13: r = 16'd32669;
      5'd14: r = 16'd32708;
      5'd15: r = 16'd32732;
      default: r = 16'd32746;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] finish_neuron(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] r;
    logic signed [15:0]    o;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
    r = s >>> FRAC_BITS;
    if (r > 32767) o = 16'sh7fff;
    else if (r < -32768) o = 16'sh8000;
    else o = r[15:0];
    return o;
  endfunction

  function automatic logic signed [15:0] tanh_fixed(input logic signed [15:0] v);
    logic [16:0] t;
    logic [16:0] seg;
    logic [SEG_SHIFT-1:0] fr;
    logic [15:0] a;
    logic [15:0] b;
    logic [31:0] p;
    logic [16:0] y;
    logic [16:0] r;
    t = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    seg = t >> SEG_SHIFT;
    fr = t[SEG_SHIFT-1:0];
    a = tanh_entry(seg[4:0]);
    b = tanh_entry(5'(seg[4:0] + 5'd1));
    p = 32'(b - a) * 32'(fr);
    if (seg >= 17'd16) y = 17'd32768;
    else y = 17'(a) + 17'(p >> SEG_SHIFT);
    r = (y + 17'(1 << (14 - FRAC_BITS))) >> (15 - FRAC_BITS);
    return v[15] ? 16'(-$signed(r)) : r[15:0];
  endfunction

endpackage

FILE: rtl/dense_mlp_tanh_inference_top.sv
`timescale 1ns / 1ps
// channel  valid       ready       payload
// request  req_valid_i req_ready_o req_i (command, index, value, last_element)
// result   rsp_valid_o rsp_ready_i rsp_o (out_index, out_value, out_last)
// Loads and non-final features are written straight into the stores.
// A final feature runs the single MAC over each neuron's weights (1280 in
// all), then drain, bias and round per neuron, and then emits each output.
// Reset clears control only; stores hold nothing until written.
// Requests stall while an evaluation runs or a result waits.
module dense_mlp_tanh_inference_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  dmlp_pkg::req_t   req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output dmlp_pkg::rsp_t   rsp_o
);
  import dmlp_pkg::*;

  logic signed [15:0] wmem [W_DEPTH];
  logic signed [15:0] bmem [B_DEPTH];
  logic signed [15:0] vmem [VDEPTH];

  state_e state_q, state_d;
  layer_e layer_q, layer_d;
  logic [CW-1:0]  col_q, col_d;
  logic [CW-1:0]  row_q, row_d;
  logic [WAW-1:0] wa_q, wa_d;
  logic [BAW-1:0] ba_q, ba_d;
  logic [VAW-1:0] vbase_q, vbase_d;
  logic [VAW-1:0] obase_q, obase_d;
  logic [3:0]     oidx_q, oidx_d;
  logic           rv_q, rv_d;
  rsp_t           rsp_q, rsp_d;

  logic signed [15:0] wr_q, vr_q, br_q;
  logic               vld_q;

  logic           we_w, we_b, we_v;
  logic [WAW-1:0] w_wa;
  logic [VAW-1:0] v_wa, v_ra;
  logic signed [15:0] v_wd;
  logic           rd_en;
  mac_ctl_t       ctl;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0] neu, act;
  logic [CW-1:0]  ncols, nrows;
  logic           acc_req;

  assign acc_req = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == ST_IDLE) && !rv_q;

  always_ff @(posedge clk_i) begin
    if (we_w) wmem[w_wa] <= req_i.value;
    if (we_b) bmem[req_i.index[BAW-1:0]] <= req_i.value;
    if (we_v) vmem[v_wa] <= v_wd;
    wr_q <= wmem[wa_q];
    br_q <= bmem[ba_q];
    vr_q <= vmem[v_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= rd_en;
  end

  dmlp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .a_i    (state_q == ST_BIAS ? br_q : wr_q),
    .b_i    (vr_q),
    .acc_o  (acc)
  );

  assign neu = finish_neuron(acc);
  assign act = tanh_fixed(neu);
  assign w_wa = req_i.index[WAW-1:0];
  assign v_ra = VAW'(vbase_q + VAW'(col_q));

  always_comb begin
    unique case (layer_q)
      LAYER_ONE: begin ncols = CW'(IN_COUNT);   nrows = CW'(HIDDEN_ONE); end
      LAYER_TWO: begin ncols = CW'(HIDDEN_ONE); nrows = CW'(HIDDEN_TWO); end
      default:   begin ncols = CW'(HIDDEN_TWO); nrows = CW'(OUT_COUNT);  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      layer_q <= LAYER_ONE;
      col_q   <= '0;
      row_q   <= '0;
      wa_q    <= '0;
      ba_q    <= '0;
      vbase_q <= '0;
      obase_q <= '0;
      oidx_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      col_q   <= col_d;
      row_q   <= row_d;
      wa_q    <= wa_d;
      ba_q    <= ba_d;
      vbase_q <= vbase_d;
      obase_q <= obase_d;
      oidx_q  <= oidx_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) rsp_q <= rsp_d;

  always_comb begin
    state_d = state_q;
    layer_d = layer_q;
    col_d   = col_q;
    row_d   = row_q;
    wa_d    = wa_q;
    ba_d    = ba_q;
    vbase_d = vbase_q;
    obase_d = obase_q;
    oidx_d  = oidx_q;
    rv_d    = rv_q;
    rsp_d   = rsp_q;
    we_w = 1'b0;
    we_b = 1'b0;
    we_v = 1'b0;
    v_wa = req_i.index[VAW-1:0];
    v_wd = req_i.value;
    rd_en = 1'b0;
    ctl = '0;
    if (rv_q && rsp_ready_i) rv_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_req) begin
          case (req_i.command)
            CMD_WEIGHT:  we_w = (req_i.index < 11'(W_DEPTH));
            CMD_BIAS:    we_b = (req_i.index < 11'(B_DEPTH));
            CMD_FEATURE: begin
              we_v = (req_i.index < 11'(IN_COUNT));
              if (req_i.last_element) begin
                state_d = ST_RUN;
                layer_d = LAYER_ONE;
                col_d = '0;
                row_d = '0;
                wa_d = WAW'(W1_BASE);
                ba_d = BAW'(B1_BASE);
                vbase_d = '0;
                obase_d = VAW'(IN_COUNT);
                oidx_d = '0;
                ctl.clear = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        rd_en = 1'b1;
        ctl.mac = vld_q;
        wa_d = WAW'(wa_q + WAW'(1));
        if (col_q == ncols - CW'(1)) state_d = ST_DRAIN;
        else col_d = CW'(col_q + CW'(1));
      end
      ST_DRAIN: begin
        ctl.mac = vld_q;
        state_d = ST_BIAS;
      end
      ST_BIAS: begin
        ctl.add_bias = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        col_d = '0;
        ba_d = BAW'(ba_q + BAW'(1));
        if (layer_q == LAYER_OUT) begin
          state_d = ST_EMIT;
        end else begin
          we_v = 1'b1;
          v_wa = VAW'(obase_q + VAW'(row_q));
          v_wd = act;
          ctl.clear = 1'b1;
          if (row_q == nrows - CW'(1)) begin
            row_d = '0;
            vbase_d = obase_q;
            obase_d = VAW'(obase_q + VAW'(nrows));
            layer_d = (layer_q == LAYER_ONE) ? LAYER_TWO : LAYER_OUT;
          end else row_d = CW'(row_q + CW'(1));
          state_d = ST_RUN;
        end
      end
      ST_EMIT: begin
        if (!rv_q) begin
          rv_d = 1'b1;
          rsp_d.out_index = oidx_q[2:0];
          rsp_d.out_value = neu;
          rsp_d.out_last  = (row_q == nrows - CW'(1));
          ctl.clear = 1'b1;
          oidx_d = 4'(oidx_q + 4'd1);
          if (row_q == nrows - CW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            row_d = CW'(row_q + CW'(1));
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o = rsp_q;
endmodule

FILE: rtl/dmlp_mac.sv
`timescale 1ns / 1ps
module dmlp_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dmlp_pkg::mac_ctl_t        ctl_i,
  input  logic signed [15:0]        a_i,
  input  logic signed [15:0]        b_i,
  output logic signed [dmlp_pkg::ACC_W-1:0] acc_o
);
  import dmlp_pkg::*;

  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc_d, acc_q;

  assign prod = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) acc_d = '0;
    else if (ctl_i.mac) acc_d = acc_q + ACC_W'(prod);
    else if (ctl_i.add_bias) acc_d = acc_q + (ACC_W'(a_i) <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else acc_q <= acc_d;
  end

  assign acc_o = acc_q;
endmodule
